// ===== hdl/lspt_pkg.sv =====
// Package for the laser scan point transform: item types, register codes,
// CORDIC constants. No dependencies.
`timescale 1ns / 1ps

package lspt_pkg;

  localparam int MAX_SCAN_SAMPLES = 4096;
  localparam int SAMPLE_IDX_W     = 12;
  localparam int CORDIC_ITERS     = 30;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 64;

  // gain-compensated 1.0 in Q2.30, and 1.0 itself
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;

  // arctangent of 2^-i in binary angle units
  localparam logic signed [31:0] ATAN_BAM [CORDIC_ITERS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
    32'sd21354465,  32'sd10679838,  32'sd5340245,   32'sd2670163,  32'sd1335087,
    32'sd667544,    32'sd333772,    32'sd166886,    32'sd83443,    32'sd41722,
    32'sd20861,     32'sd10430,     32'sd5215,      32'sd2608,     32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,       32'sd41,
    32'sd20,        32'sd10,        32'sd5,         32'sd3,        32'sd1
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_XX         = 3'd0,
    CFG_ROT_XY         = 3'd1,
    CFG_ROT_YX         = 3'd2,
    CFG_ROT_YY         = 3'd3,
    CFG_TRANSLATION_XY = 3'd4,
    CFG_RANGE_LIMITS   = 3'd5,
    CFG_ANGLE_START    = 3'd6,
    CFG_ANGLE_STEP     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]             range_value;
    logic                    range_not_finite;
    logic [SAMPLE_IDX_W-1:0] sample_index;
    logic                    scan_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] map_x;
    logic signed [31:0] map_y;
    logic               point_valid;
    logic               scan_last;
  } out_item_t;

  // sideband that travels with an item through the angle and CORDIC stages
  typedef struct packed {
    logic [31:0] range;
    logic        ok;
    logic        last;
    logic [1:0]  quad;
  } side_t;

endpackage

// ===== hdl/lspt_in_if.sv =====
// Valid/ready channel carrying one range sample item.
// Depends on lspt_pkg.
`timescale 1ns / 1ps

interface lspt_in_if;
  logic               valid;
  logic               ready;
  lspt_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/lspt_out_if.sv =====
// Valid/ready channel carrying one map point item.
// Depends on lspt_pkg.
`timescale 1ns / 1ps

interface lspt_out_if;
  logic                valid;
  logic                ready;
  lspt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/laser_scan_point_transform_unit.sv =====
// Takes one item per cycle while the output buffer's spare slot is free. Pipeline: range
// filter and angle multiply, CORDIC entry, 30 CORDIC stages (one rotation each), quadrant
// unfold, two multiply/round pairs and a saturating output stage, all advancing together.
// A two-entry output buffer holds results so a stalled sink never drops an in-flight item.
// Reset (async, active low) clears all valid bits and loads the registers' reset values.
`timescale 1ns / 1ps

module laser_scan_point_transform_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lspt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lspt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  lspt_in_if.sink                             sample_i,
  lspt_out_if.source                          point_o
);

  localparam int NI = lspt_pkg::CORDIC_ITERS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] rot_xx_q, rot_xy_q, rot_yx_q, rot_yy_q;
  logic signed [31:0] tx_q, ty_q;
  logic [31:0]        rmin_q, rmax_q;
  logic [31:0]        ang_start_q;
  logic [31:0]        ang_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_xx_q    <= lspt_pkg::ONE_Q30;
      rot_xy_q    <= '0;
      rot_yx_q    <= '0;
      rot_yy_q    <= lspt_pkg::ONE_Q30;
      tx_q        <= '0;
      ty_q        <= '0;
      rmin_q      <= '0;
      rmax_q      <= '1;
      ang_start_q <= '0;
      ang_step_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (lspt_pkg::cfg_idx_e'(cfg_idx_i))
        lspt_pkg::CFG_ROT_XX:         rot_xx_q <= cfg_data_i[31:0];
        lspt_pkg::CFG_ROT_XY:         rot_xy_q <= cfg_data_i[31:0];
        lspt_pkg::CFG_ROT_YX:         rot_yx_q <= cfg_data_i[31:0];
        lspt_pkg::CFG_ROT_YY:         rot_yy_q <= cfg_data_i[31:0];
        lspt_pkg::CFG_TRANSLATION_XY: begin
          tx_q <= cfg_data_i[31:0];
          ty_q <= cfg_data_i[63:32];
        end
        lspt_pkg::CFG_RANGE_LIMITS: begin
          rmin_q <= cfg_data_i[31:0];
          rmax_q <= cfg_data_i[63:32];
        end
        lspt_pkg::CFG_ANGLE_START:    ang_start_q <= cfg_data_i[31:0];
        lspt_pkg::CFG_ANGLE_STEP:     ang_step_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage advances together while the output buffer
  // has its spare slot free. The spare slot absorbs the one item that may
  // arrive in the cycle the sink stalls, so ready never depends on the sink.
  // ---------------------------------------------------------------------------
  logic adv;
  logic spare_v_q;

  assign adv            = !spare_v_q;
  assign sample_i.ready = adv;

  logic in_acc;
  assign in_acc = sample_i.valid && adv;

  // ---------------------------------------------------------------------------
  // Stage A: range filter and index * step
  // ---------------------------------------------------------------------------
  logic               a_v_q;
  lspt_pkg::side_t    a_side_q;
  logic [31:0]        a_off_q;
  logic               in_ok;

  assign in_ok = !sample_i.data.range_not_finite
              && (sample_i.data.range_value >= rmin_q)
              && (sample_i.data.range_value <= rmax_q)
              && (32'(sample_i.data.sample_index) < 32'(lspt_pkg::MAX_SCAN_SAMPLES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_side_q.range <= sample_i.data.range_value;
      a_side_q.ok    <= in_ok;
      a_side_q.last  <= sample_i.data.scan_end;
      a_side_q.quad  <= '0;
      // wraps modulo 2^32, same as signed step in two's complement
      a_off_q        <= 32'(32'(sample_i.data.sample_index) * ang_step_q);
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC: entry stage 0 holds the start vector, stage i+1 holds the vector
  // after rotation i.
  // ---------------------------------------------------------------------------
  logic                cv_q    [NI+1];
  lspt_pkg::side_t     cside_q [NI+1];
  logic signed [31:0]  cx_q    [NI+1];
  logic signed [31:0]  cy_q    [NI+1];
  logic signed [31:0]  cz_q    [NI+1];
  logic [31:0]         angle;

  assign angle = ang_start_q + a_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (adv) begin
      cv_q[0] <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cside_q[0].range <= a_side_q.range;
      cside_q[0].ok    <= a_side_q.ok;
      cside_q[0].last  <= a_side_q.last;
      cside_q[0].quad  <= angle[31:30];
      cx_q[0]          <= lspt_pkg::CORDIC_GAIN_Q30;
      cy_q[0]          <= '0;
      cz_q[0]          <= $signed({2'b00, angle[29:0]});
    end
  end

  for (genvar i = 0; i < NI; i++) begin : g_cordic
    logic signed [31:0] dx, dy;

    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (adv) begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cside_q[i+1] <= cside_q[i];
        if (!cz_q[i][31]) begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - lspt_pkg::ATAN_BAM[i];
        end else begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + lspt_pkg::ATAN_BAM[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: clamp to +-1.0 and unfold the quadrant
  // ---------------------------------------------------------------------------
  logic               c_v_q;
  logic [31:0]        c_range_q;
  logic               c_ok_q, c_last_q;
  logic signed [31:0] c_co_q, c_si_q;
  logic signed [31:0] xc, yc;
  logic signed [31:0] co_d, si_d;

  always_comb begin
    xc = cx_q[NI];
    yc = cy_q[NI];
    if (xc > lspt_pkg::ONE_Q30)  xc = lspt_pkg::ONE_Q30;
    if (xc < -lspt_pkg::ONE_Q30) xc = -lspt_pkg::ONE_Q30;
    if (yc > lspt_pkg::ONE_Q30)  yc = lspt_pkg::ONE_Q30;
    if (yc < -lspt_pkg::ONE_Q30) yc = -lspt_pkg::ONE_Q30;
    case (cside_q[NI].quad)
      2'd0:    begin co_d = xc;  si_d = yc;  end
      2'd1:    begin co_d = -yc; si_d = xc;  end
      2'd2:    begin co_d = -xc; si_d = -yc; end
      default: begin co_d = yc;  si_d = -xc; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (adv) begin
      c_v_q <= cv_q[NI];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_range_q <= cside_q[NI].range;
      c_ok_q    <= cside_q[NI].ok;
      c_last_q  <= cside_q[NI].last;
      c_co_q    <= co_d;
      c_si_q    <= si_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage M1: range * cos, range * sin
  // ---------------------------------------------------------------------------
  logic               m1_v_q, m1_ok_q, m1_last_q;
  logic signed [64:0] m1_px_q, m1_py_q;
  logic signed [32:0] rng_s;

  assign rng_s = $signed({1'b0, c_range_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (adv) begin
      m1_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_ok_q   <= c_ok_q;
      m1_last_q <= c_last_q;
      m1_px_q   <= 65'(rng_s) * 65'(c_co_q);
      m1_py_q   <= 65'(rng_s) * 65'(c_si_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage M2: round half up to Q16.16 (fits 33 bits signed)
  // ---------------------------------------------------------------------------
  logic               m2_v_q, m2_ok_q, m2_last_q;
  logic signed [32:0] m2_lx_q, m2_ly_q;
  logic signed [64:0] px_r, py_r;

  assign px_r = m1_px_q + 65'sd536870912;
  assign py_r = m1_py_q + 65'sd536870912;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (adv) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_ok_q   <= m1_ok_q;
      m2_last_q <= m1_last_q;
      m2_lx_q   <= px_r[62:30];
      m2_ly_q   <= py_r[62:30];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage M3: rotation products
  // ---------------------------------------------------------------------------
  logic               m3_v_q, m3_ok_q, m3_last_q;
  logic signed [64:0] m3_xx_q, m3_xy_q, m3_yx_q, m3_yy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_v_q <= 1'b0;
    end else if (adv) begin
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m3_ok_q   <= m2_ok_q;
      m3_last_q <= m2_last_q;
      m3_xx_q   <= 65'(rot_xx_q) * 65'(m2_lx_q);
      m3_xy_q   <= 65'(rot_xy_q) * 65'(m2_ly_q);
      m3_yx_q   <= 65'(rot_yx_q) * 65'(m2_lx_q);
      m3_yy_q   <= 65'(rot_yy_q) * 65'(m2_ly_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage M4: round each product and add the translation
  // ---------------------------------------------------------------------------
  logic               m4_v_q, m4_ok_q, m4_last_q;
  logic signed [36:0] m4_mx_q, m4_my_q;
  logic signed [64:0] xx_r, xy_r, yx_r, yy_r;
  logic signed [34:0] xx_s, xy_s, yx_s, yy_s;

  assign xx_r = m3_xx_q + 65'sd536870912;
  assign xy_r = m3_xy_q + 65'sd536870912;
  assign yx_r = m3_yx_q + 65'sd536870912;
  assign yy_r = m3_yy_q + 65'sd536870912;
  assign xx_s = xx_r[64:30];
  assign xy_s = xy_r[64:30];
  assign yx_s = yx_r[64:30];
  assign yy_s = yy_r[64:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m4_v_q <= 1'b0;
    end else if (adv) begin
      m4_v_q <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m4_ok_q   <= m3_ok_q;
      m4_last_q <= m3_last_q;
      m4_mx_q   <= 37'(xx_s) + 37'(xy_s) + 37'(tx_q);
      m4_my_q   <= 37'(yx_s) + 37'(yy_s) + 37'(ty_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Saturate, zero dropped samples, and form the result item
  // ---------------------------------------------------------------------------
  localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
  localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

  lspt_pkg::out_item_t push_item;
  logic                push;

  always_comb begin
    push_item.point_valid = m4_ok_q;
    push_item.scan_last   = m4_last_q;
    if (!m4_ok_q) begin
      push_item.map_x = '0;
    end else if (m4_mx_q > SAT_MAX) begin
      push_item.map_x = SAT_MAX[31:0];
    end else if (m4_mx_q < SAT_MIN) begin
      push_item.map_x = SAT_MIN[31:0];
    end else begin
      push_item.map_x = m4_mx_q[31:0];
    end
    if (!m4_ok_q) begin
      push_item.map_y = '0;
    end else if (m4_my_q > SAT_MAX) begin
      push_item.map_y = SAT_MAX[31:0];
    end else if (m4_my_q < SAT_MIN) begin
      push_item.map_y = SAT_MIN[31:0];
    end else begin
      push_item.map_y = m4_my_q[31:0];
    end
  end

  assign push = adv && m4_v_q;

  // ---------------------------------------------------------------------------
  // Output register plus spare slot
  // ---------------------------------------------------------------------------
  logic                out_v_q;
  lspt_pkg::out_item_t out_q, spare_q;
  logic                pop;

  assign pop           = out_v_q && point_o.ready;
  assign point_o.valid = out_v_q;
  assign point_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
    end else if (!out_v_q || pop) begin
      // head slot frees up: refill from spare first to keep order
      if (spare_v_q) begin
        out_v_q   <= 1'b1;
        spare_v_q <= push;
      end else begin
        out_v_q   <= push;
      end
    end else if (push) begin
      spare_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      if (spare_v_q) begin
        out_q <= spare_q;
        if (push) spare_q <= push_item;
      end else if (push) begin
        out_q <= push_item;
      end
    end else if (push) begin
      spare_q <= push_item;
    end
  end

endmodule
